// File: rtl/pngain_pkg.sv
// Shared types and constants for the peak normalising gain core.
package pngain_pkg;

	// Field widths
	localparam int unsigned SampleW = 24;
	localparam int unsigned PeriodW = 20;
	localparam int unsigned ProdW   = 2 * SampleW - 1;

	// Full-scale numerators and the decay reciprocal
	localparam logic [SampleW-1:0] FullPos  = 24'h7FFFFF;
	localparam logic [SampleW-1:0] FullNeg  = 24'h800000;
	localparam logic [SampleW-1:0] Recip3   = 24'hAAAAAB;
	localparam int unsigned        Recip3Sh = 25;
	localparam logic [PeriodW-1:0] PeriodRst = 20'd48000;

	// Divider schedule: one quotient bit per step
	localparam int unsigned DivSteps = SampleW;
	localparam int unsigned CountW   = $clog2(DivSteps);

	// Configuration register indexes
	localparam logic RegDecayPeriod = 1'b0;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PEAK,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} pngain_state_t;

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic load;
		logic peak;
		logic prep;
		logic step;
		logic publish;
	} pngain_cmd_t;

endpackage

// File: rtl/pngain_ctrl.sv
// Sequencer for the peak normalising gain core: handshakes and divider schedule.
module pngain_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  logic                     out_stall,
	output pngain_pkg::pngain_cmd_t  cmd
);
	import pngain_pkg::*;

	pngain_state_t     state_q, state_nxt;
	logic [CountW-1:0] count_q;
	logic              out_valid_q;
	logic              out_free;

	// The output register may be loaded when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_PEAK;
			end
			ST_PEAK: state_nxt = ST_PREP;
			ST_PREP: state_nxt = ST_DIV;
			ST_DIV: begin
				if (count_q == CountW'(DivSteps - 1)) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_PEAK: cmd.peak = 1'b1;
			ST_PREP: cmd.prep = 1'b1;
			ST_DIV:  cmd.step = 1'b1;
			ST_DONE: cmd.publish = out_free;
			default: cmd = '0;
		endcase
	end

	// State, step counter and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.prep) begin
				count_q <= '0;
			end else if (cmd.step) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/pngain_dp.sv
// Datapath for the peak normalising gain core: peak tracking, decay and divider.
module pngain_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pngain_pkg::pngain_cmd_t               cmd,
	input  logic [pngain_pkg::PeriodW-1:0]        decay_period,
	input  logic signed [pngain_pkg::SampleW-1:0] sample,
	output logic signed [pngain_pkg::SampleW-1:0] scaled_sample,
	output logic                                  clipped
);
	import pngain_pkg::*;

	// Tracked state; the low peak is kept as its magnitude
	logic [SampleW-1:0] high_q;
	logic [SampleW-1:0] low_mag_q;
	logic [PeriodW-1:0] window_q;

	// Item registers
	logic signed [SampleW-1:0] sample_q;
	logic                      pos_q;
	logic                      clip_q;
	logic [SampleW-1:0]        den_q;
	logic [SampleW-1:0]        rem_q;
	logic [SampleW-1:0]        num_q;
	logic [SampleW-1:0]        quo_q;
	logic signed [SampleW-1:0] scaled_q;
	logic                      clipped_q;

	logic                      pos;
	logic [SampleW-1:0]        mag;
	logic [SampleW-1:0]        den;
	logic [ProdW-1:0]          num;
	logic [2*SampleW-1:0]      high_prod;
	logic [2*SampleW-1:0]      low_prod;
	logic [SampleW-1:0]        high_div3;
	logic [SampleW-1:0]        low_div3;
	logic                      new_high;
	logic                      new_low;
	logic [SampleW:0]          trial;

	// Sign and magnitude of the held sample
	assign pos = !sample_q[SampleW-1] && (sample_q != '0);
	assign mag = sample_q[SampleW-1] ? (~sample_q + 1'b1) : sample_q;

	// Peak comparisons
	assign new_high = pos && (mag > high_q);
	assign new_low  = sample_q[SampleW-1] && (mag > low_mag_q);

	// Decay by three through the reciprocal, truncating toward zero
	assign high_prod = high_q * Recip3;
	assign low_prod  = low_mag_q * Recip3;
	assign high_div3 = SampleW'(high_prod >> Recip3Sh);
	assign low_div3  = SampleW'(low_prod >> Recip3Sh);

	// Numerator and denominator: full scale times the magnitude
	assign den = pos ? high_q : low_mag_q;
	assign num = pos ? (({mag, (SampleW-1)'(0)}) - ProdW'(mag)) : {mag, (SampleW-1)'(0)};

	// One restoring step: trial subtract of the denominator
	assign trial = {rem_q, num_q[SampleW-1]} - {1'b0, den_q};

	// Window counter and peaks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q    <= SampleW'(1);
			low_mag_q <= SampleW'(1);
			window_q  <= '0;
		end else if (cmd.peak) begin
			if (window_q < decay_period) begin
				window_q <= window_q + 1'b1;
				if (new_high) high_q <= mag;
				if (new_low) low_mag_q <= mag;
			end else begin
				window_q  <= '0;
				high_q    <= (high_div3 == '0) ? SampleW'(1) : high_div3;
				low_mag_q <= (low_div3 == '0) ? SampleW'(1) : low_div3;
			end
		end
	end

	// Item capture, division set-up, division steps and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
		end
		if (cmd.prep) begin
			pos_q  <= pos;
			clip_q <= mag > den;
			den_q  <= den;
			rem_q  <= SampleW'(num >> SampleW);
			num_q  <= num[SampleW-1:0];
			quo_q  <= '0;
		end
		if (cmd.step) begin
			num_q <= num_q << 1;
			if (!trial[SampleW]) begin
				rem_q <= trial[SampleW-1:0];
				quo_q <= {quo_q[SampleW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SampleW-2:0], num_q[SampleW-1]};
				quo_q <= {quo_q[SampleW-2:0], 1'b0};
			end
		end
		if (cmd.publish) begin
			clipped_q <= clip_q;
			if (clip_q) begin
				scaled_q <= pos_q ? FullPos : FullNeg;
			end else begin
				scaled_q <= pos_q ? quo_q : (~quo_q + 1'b1);
			end
		end
	end

	assign scaled_sample = scaled_q;
	assign clipped       = clipped_q;

endmodule

// File: rtl/peak_normalizing_gain_core.sv
// Top level of the peak normalising gain core: register port, sequencer and datapath.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    sample
// out       output     out_valid / out_stall  scaled_sample, clipped
// apb       config     psel, penable, pready  paddr, pwdata, prdata
//
// After the edge that accepts an item come the peak update, the divider set-up,
// 24 restoring division steps (one quotient bit each) and the result load.
// The next item is taken only after the result load; the divider sets the item rate.
// Reset: high peak 1, low peak -1, window count 0, decay period 48000.
// A stalled result waits in the output register while the next item is taken in.
module peak_normalizing_gain_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [pngain_pkg::SampleW-1:0] sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [pngain_pkg::SampleW-1:0] scaled_sample,
	output logic                                  clipped,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [2:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);
	import pngain_pkg::*;

	pngain_cmd_t        cmd;
	logic [PeriodW-1:0] decay_period_q;
	logic               cfg_wr;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_period_q <= PeriodRst;
		end else if (cfg_wr && (paddr[2] == RegDecayPeriod)) begin
			decay_period_q <= pwdata[PeriodW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == RegDecayPeriod) prdata = 32'(decay_period_q);
	end

	// Sequencer
	pngain_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Datapath
	pngain_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.decay_period  (decay_period_q),
		.sample        (sample),
		.scaled_sample (scaled_sample),
		.clipped       (clipped)
	);

	// One item at a time: an accepted item closes the input until its result is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an item is in progress");

	// A saturated result is always full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped) |-> (scaled_sample == 24'sh7FFFFF ||
			scaled_sample == 24'sh800000))
		else $error("clipped result is not at full scale");

endmodule
